[rtl/cir_pkg.sv]
// Shared types, codes and helpers for the contact impulse resolver.
// Used by every module of the block; depends on nothing else.
package cir_pkg;

  // Fixed field widths of the data path.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned UMAG_W = 31;
  localparam int unsigned REST_W = 17;
  localparam int unsigned QUOT_W = 31;
  localparam int unsigned IN_DATA_W = 320;
  localparam int unsigned OUT_DATA_W = 288;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_NO_CONTACT = 2'd0,
    ST_SEPARATING = 2'd1,
    ST_IMMOVABLE  = 2'd2,
    ST_RESOLVED   = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_PERCENT = 1'b0,
    REG_SLOP    = 1'b1
  } cfg_reg_e;

  // Per-contact values that ride along the pipeline beside the arithmetic.
  typedef struct packed {
    status_e            status;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic [30:0]        ima;
    logic [30:0]        imb;
  } side_t;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/contact_impulse_resolver.sv]
// Contact impulse resolver, top level. Instantiates cir_front, cir_div and
// cir_back; depends on cir_pkg.
//
// One contact transfer is accepted every clock cycle while the result side
// takes data; each contact gives exactly one result, after 4 front stages,
// 32 divider stages and 4 back stages. The divider stages resolve
// the two saturating quotients, impulse and position correction over the sum
// of inverse masses, which are resolved one bit per pipeline stage. A stall
// on the result side freezes the whole pipeline and s_axis_tready falls.
// Configuration writes are taken in any cycle and should be made while no
// contact is in flight.
module contact_impulse_resolver #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Contact input. tdata: normal_x, normal_y, normal_z, penetration,
  // rel_vel_x, rel_vel_y, rel_vel_z, inv_mass_a, inv_mass_b,
  // restitution_a, restitution_b, zero pad. tuser: contact.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [319:0]  s_axis_tdata,
  input  logic          s_axis_tuser,
  // Result output. tdata: impulse_x/y/z, shift_a_x/y/z, shift_b_x/y/z.
  // tuser: status.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [287:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,
  // Configuration write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  logic [30:0]   cfg_data_i
);

  localparam int unsigned MW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int unsigned VW = 66 - FRAC_BITS;
  localparam int unsigned NW = MW + VW;

  logic en;
  logic [16:0] percent_q;
  logic [30:0] slop_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      percent_q <= 17'd52429;
      slop_q <= 31'd655;
    end else if (cfg_valid_i) begin
      unique case (cir_pkg::cfg_reg_e'(cfg_index_i))
        cir_pkg::REG_PERCENT: percent_q <= cfg_data_i[16:0];
        cir_pkg::REG_SLOP:    slop_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held back.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic           f_vld;
  logic [NW-1:0]  f_nj;
  logic [47:0]    f_nc;
  logic [31:0]    f_div;
  cir_pkg::side_t f_side;

  cir_front #(
    .FRAC_BITS(FRAC_BITS),
    .MW(MW),
    .VW(VW)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .en_i(en),
    .vld_i(s_axis_tvalid),
    .contact_i(s_axis_tuser),
    .nx_i(s_axis_tdata[31:0]),
    .ny_i(s_axis_tdata[63:32]),
    .nz_i(s_axis_tdata[95:64]),
    .pen_i(s_axis_tdata[126:96]),
    .rvx_i(s_axis_tdata[158:127]),
    .rvy_i(s_axis_tdata[190:159]),
    .rvz_i(s_axis_tdata[222:191]),
    .ima_i(s_axis_tdata[253:223]),
    .imb_i(s_axis_tdata[284:254]),
    .ra_i(s_axis_tdata[301:285]),
    .rb_i(s_axis_tdata[318:302]),
    .percent_i(percent_q),
    .slop_i(slop_q),
    .vld_o(f_vld),
    .nj_o(f_nj),
    .nc_o(f_nc),
    .div_o(f_div),
    .side_o(f_side)
  );

  logic           d_vld;
  logic [30:0]    d_jq, d_cq;
  logic           d_jov, d_cov;
  cir_pkg::side_t d_side;

  cir_div #(
    .AW(NW),
    .BW(48)
  ) u_div (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .en_i(en),
    .vld_i(f_vld),
    .na_i(f_nj),
    .nb_i(f_nc),
    .d_i(f_div),
    .side_i(f_side),
    .vld_o(d_vld),
    .qa_o(d_jq),
    .ova_o(d_jov),
    .qb_o(d_cq),
    .ovb_o(d_cov),
    .side_o(d_side)
  );

  cir_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .en_i(en),
    .vld_i(d_vld),
    .jq_i(d_jq),
    .jov_i(d_jov),
    .cq_i(d_cq),
    .cov_i(d_cov),
    .side_i(d_side),
    .vld_o(m_axis_tvalid),
    .status_o(m_axis_tuser),
    .data_o(m_axis_tdata)
  );

  // Any result that was not resolved carries no impulse and no shift.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != cir_pkg::ST_RESOLVED) |-> (m_axis_tdata == '0))
    else $error("unresolved result carries nonzero data");

  // A held result and the pipeline behind it stay frozen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
                        $stable(m_axis_tuser) && $stable(f_vld)))
    else $error("pipeline moved during a stall");

endmodule

[rtl/cir_front.sv]
// Front stages of the resolver: closing speed, restitution, mass sum and
// the two dividends. Depends on cir_pkg.
module cir_front #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MW = 18,
  parameter int unsigned VW = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic                 contact_i,
  input  logic signed [31:0]   nx_i,
  input  logic signed [31:0]   ny_i,
  input  logic signed [31:0]   nz_i,
  input  logic [30:0]          pen_i,
  input  logic signed [31:0]   rvx_i,
  input  logic signed [31:0]   rvy_i,
  input  logic signed [31:0]   rvz_i,
  input  logic [30:0]          ima_i,
  input  logic [30:0]          imb_i,
  input  logic [16:0]          ra_i,
  input  logic [16:0]          rb_i,
  input  logic [16:0]          percent_i,
  input  logic [30:0]          slop_i,
  output logic                 vld_o,
  output logic [MW+VW-1:0]     nj_o,
  output logic [47:0]          nc_o,
  output logic [31:0]          div_o,
  output cir_pkg::side_t       side_o
);

  localparam int unsigned VL = (VW + 1) / 2;
  localparam int unsigned VH = VW - VL;
  localparam int unsigned NW = MW + VW;

  logic [3:0] vld_q;

  // Stage 1: dot product terms, mass sum, excess depth, early status.
  logic signed [63:0] p0_q, p1_q, p2_q;
  logic [16:0]        e1_q;
  logic [31:0]        s1_q;
  logic [30:0]        x1_q;
  cir_pkg::side_t     side1_d, side1_q;
  logic [31:0]        s1_d;
  logic [30:0]        x1_d;

  always_comb begin
    s1_d = {1'b0, ima_i} + {1'b0, imb_i};
    x1_d = (pen_i > slop_i) ? (pen_i - slop_i) : '0;
    side1_d.nx = nx_i;
    side1_d.ny = ny_i;
    side1_d.nz = nz_i;
    side1_d.ima = ima_i;
    side1_d.imb = imb_i;
    if (s1_d == '0) begin
      side1_d.status = cir_pkg::ST_IMMOVABLE;
    end else if (!contact_i) begin
      side1_d.status = cir_pkg::ST_NO_CONTACT;
    end else begin
      side1_d.status = cir_pkg::ST_RESOLVED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= rvx_i * nx_i;
      p1_q <= rvy_i * ny_i;
      p2_q <= rvz_i * nz_i;
      e1_q <= (ra_i < rb_i) ? ra_i : rb_i;
      s1_q <= s1_d;
      x1_q <= x1_d;
      side1_q <= side1_d;
    end
  end

  // Stage 2: normal speed, separating test, restitution factor, correction numerator.
  logic [VW-1:0]  v2_d, v2_q;
  logic [MW-1:0]  m2_q;
  logic [47:0]    xp2_q;
  logic [31:0]    s2_q;
  cir_pkg::side_t side2_d, side2_q;

  always_comb begin
    logic signed [65:0] sum;
    logic signed [65:0] vn;
    sum = 66'(p0_q) + 66'(p1_q) + 66'(p2_q);
    vn = sum >>> FRAC_BITS;
    v2_d = VW'(-vn);
    side2_d = side1_q;
    if (side1_q.status == cir_pkg::ST_RESOLVED && !vn[65] && vn != '0) begin
      side2_d.status = cir_pkg::ST_SEPARATING;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v2_q <= v2_d;
      m2_q <= (MW'(1) << FRAC_BITS) + MW'(e1_q);
      xp2_q <= 48'(x1_q) * 48'(percent_i);
      s2_q <= s1_q;
      side2_q <= side2_d;
    end
  end

  // Stage 3: restitution factor times speed, split in two partial products.
  logic [MW+VL-1:0] pl3_q;
  logic [MW+VH-1:0] ph3_q;
  logic [47:0]      xp3_q;
  logic [31:0]      s3_q;
  cir_pkg::side_t   side3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl3_q <= (MW+VL)'(m2_q) * (MW+VL)'(v2_q[VL-1:0]);
      ph3_q <= (MW+VH)'(m2_q) * (MW+VH)'(v2_q[VW-1:VL]);
      xp3_q <= xp2_q;
      s3_q <= s2_q;
      side3_q <= side2_q;
    end
  end

  // Stage 4: merge the partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nj_o <= NW'(pl3_q) + (NW'(ph3_q) << VL);
      nc_o <= xp3_q;
      div_o <= s3_q;
      side_o <= side3_q;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o = vld_q[3];

endmodule

[rtl/cir_div.sv]
// Pipelined restoring divider with two lanes over one divisor; quotients are
// 31 bits wide with an overflow flag per lane. Depends on cir_pkg.
module cir_div #(
  parameter int unsigned AW = 68,
  parameter int unsigned BW = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [AW-1:0]   na_i,
  input  logic [BW-1:0]   nb_i,
  input  logic [31:0]     d_i,
  input  cir_pkg::side_t  side_i,
  output logic            vld_o,
  output logic [30:0]     qa_o,
  output logic            ova_o,
  output logic [30:0]     qb_o,
  output logic            ovb_o,
  output cir_pkg::side_t  side_o
);

  localparam int unsigned QW = cir_pkg::QUOT_W;
  localparam int unsigned HA = AW - QW;
  localparam int unsigned HB = BW - QW;
  localparam int unsigned CA = (HA > 32) ? HA : 32;
  localparam int unsigned CB = (HB > 32) ? HB : 32;

  logic [QW:0]    vld_q;
  logic [QW:0]    ova_q, ovb_q;
  logic [31:0]    ra_q [QW+1];
  logic [31:0]    rb_q [QW+1];
  logic [QW-1:0]  la_q [QW+1];
  logic [QW-1:0]  lb_q [QW+1];
  logic [QW-1:0]  qa_q [QW+1];
  logic [QW-1:0]  qb_q [QW+1];
  logic [31:0]    d_q  [QW+1];
  cir_pkg::side_t side_q [QW+1];

  // Entry stage: overflow test and the initial remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ova_q[0] <= CA'(na_i[AW-1:QW]) >= CA'(d_i);
      ovb_q[0] <= CB'(nb_i[BW-1:QW]) >= CB'(d_i);
      ra_q[0] <= 32'(na_i[AW-1:QW]);
      rb_q[0] <= 32'(nb_i[BW-1:QW]);
      la_q[0] <= na_i[QW-1:0];
      lb_q[0] <= nb_i[QW-1:0];
      qa_q[0] <= '0;
      qb_q[0] <= '0;
      d_q[0] <= d_i;
      side_q[0] <= side_i;
    end
  end

  // One quotient bit per stage and lane.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [32:0] ta, tb;
    logic        ga, gb;

    always_comb begin
      ta = {ra_q[k], la_q[k][QW-1]};
      tb = {rb_q[k], lb_q[k][QW-1]};
      ga = ta >= {1'b0, d_q[k]};
      gb = tb >= {1'b0, d_q[k]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[k+1] <= ga ? 32'(ta - {1'b0, d_q[k]}) : ta[31:0];
        rb_q[k+1] <= gb ? 32'(tb - {1'b0, d_q[k]}) : tb[31:0];
        la_q[k+1] <= la_q[k] << 1;
        lb_q[k+1] <= lb_q[k] << 1;
        qa_q[k+1] <= {qa_q[k][QW-2:0], ga};
        qb_q[k+1] <= {qb_q[k][QW-2:0], gb};
        ova_q[k+1] <= ova_q[k];
        ovb_q[k+1] <= ovb_q[k];
        d_q[k+1] <= d_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], vld_i};
    end
  end

  assign vld_o  = vld_q[QW];
  assign qa_o   = qa_q[QW];
  assign qb_o   = qb_q[QW];
  assign ova_o  = ova_q[QW];
  assign ovb_o  = ovb_q[QW];
  assign side_o = side_q[QW];

endmodule

[rtl/cir_back.sv]
// Back stages of the resolver: impulse and correction along the normal,
// then per-body shifts scaled by inverse mass. Depends on cir_pkg.
module cir_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [30:0]     jq_i,
  input  logic            jov_i,
  input  logic [30:0]     cq_i,
  input  logic            cov_i,
  input  cir_pkg::side_t  side_i,
  output logic            vld_o,
  output logic [1:0]      status_o,
  output logic [287:0]    data_o
);

  logic [3:0] vld_q;

  // Stage 1: scale the normal by the impulse and by the correction.
  logic signed [63:0] pj_q [3];
  logic signed [63:0] pc_q [3];
  cir_pkg::side_t     side1_q;

  always_ff @(posedge clk_i) begin
    logic signed [31:0] j, c;
    if (en_i) begin
      j = $signed({1'b0, jov_i ? 31'h7FFF_FFFF : jq_i});
      c = $signed({1'b0, cov_i ? 31'h7FFF_FFFF : cq_i});
      pj_q[0] <= side_i.nx * j;
      pj_q[1] <= side_i.ny * j;
      pj_q[2] <= side_i.nz * j;
      pc_q[0] <= side_i.nx * c;
      pc_q[1] <= side_i.ny * c;
      pc_q[2] <= side_i.nz * c;
      side1_q <= side_i;
    end
  end

  // Stage 2: back to fixed point with saturation.
  logic signed [31:0] imp2_q [3];
  logic signed [31:0] cor2_q [3];
  cir_pkg::side_t     side2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        imp2_q[i] <= cir_pkg::sat32(66'(pj_q[i] >>> FRAC_BITS));
        cor2_q[i] <= cir_pkg::sat32(66'(pc_q[i] >>> FRAC_BITS));
      end
      side2_q <= side1_q;
    end
  end

  // Stage 3: correction times each inverse mass.
  logic signed [63:0] pa3_q [3];
  logic signed [63:0] pb3_q [3];
  logic signed [31:0] imp3_q [3];
  cir_pkg::status_e   st3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pa3_q[i] <= cor2_q[i] * $signed({1'b0, side2_q.ima});
        pb3_q[i] <= cor2_q[i] * $signed({1'b0, side2_q.imb});
        imp3_q[i] <= imp2_q[i];
      end
      st3_q <= side2_q.status;
    end
  end

  // Stage 4: output register; unresolved contacts carry all-zero data.
  always_ff @(posedge clk_i) begin
    logic signed [31:0] sa, sb;
    if (en_i) begin
      status_o <= st3_q;
      for (int i = 0; i < 3; i++) begin
        sa = cir_pkg::sat32(-(66'(pa3_q[i] >>> FRAC_BITS)));
        sb = cir_pkg::sat32(66'(pb3_q[i] >>> FRAC_BITS));
        if (st3_q == cir_pkg::ST_RESOLVED) begin
          data_o[32*i +: 32] <= imp3_q[i];
          data_o[96 + 32*i +: 32] <= sa;
          data_o[192 + 32*i +: 32] <= sb;
        end else begin
          data_o[32*i +: 32] <= '0;
          data_o[96 + 32*i +: 32] <= '0;
          data_o[192 + 32*i +: 32] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o = vld_q[3];

endmodule
